// File: sv/gfau_pkg.sv
// Shared opcodes, field constants and GF(2^8) helper functions.
package gfau_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned GF_ORDER = 255;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_INV = 3'd4;

  localparam logic [BYTE_W-1:0] GF_REDUCE = 8'h1b;
  localparam logic [BYTE_W-1:0] GF_TOPBIT = 8'h80;
  localparam logic [BYTE_W-1:0] GF_GEN    = 8'h03;

  typedef logic [255:0][BYTE_W-1:0] gf_tbl_t;

  // Multiply by x, reduced.
  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] s;
    s = {v[BYTE_W-2:0], 1'b0};
    if ((v & GF_TOPBIT) != '0) begin
      s = s ^ GF_REDUCE;
    end
    return s;
  endfunction

  // Shift-and-add carry-less product, eight narrow steps.
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                               input logic [BYTE_W-1:0] y);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] xs;
    acc = '0;
    xs  = x;
    for (int i = 0; i < BYTE_W; i++) begin
      if (y[i]) begin
        acc = acc ^ xs;
      end
      xs = gf_xtime(xs);
    end
    return acc;
  endfunction

  // Inverse table from powers of the generator; entry 0 stays 0.
  function automatic gf_tbl_t build_inv_tbl();
    gf_tbl_t tbl;
    gf_tbl_t ex;
    logic [BYTE_W-1:0] p;
    tbl = '0;
    ex  = '0;
    p   = 8'h01;
    for (int i = 0; i < GF_ORDER; i++) begin
      ex[i] = p;
      p = gf_mul(p, GF_GEN);
    end
    for (int i = 0; i < GF_ORDER; i++) begin
      tbl[ex[i]] = (i == 0) ? ex[0] : ex[GF_ORDER - i];
    end
    return tbl;
  endfunction

  localparam gf_tbl_t INV_TBL = build_inv_tbl();

endpackage

// File: sv/gf256_arithmetic_unit_top.sv
// GF(2^8) arithmetic unit (AES polynomial 0x11b), two-stage pipeline.
//
// Input channel: in_valid/in_stall with in_opcode, in_operand_a, in_operand_b.
// A word is taken at a rising edge with in_valid high and in_stall low.
// Opcodes: add, subtract (both XOR), multiply, divide a by b, inverse of a.
// Zero operands of multiply and divide, zero divisor, inverse of zero and unused opcodes give 0.
// Result channel: out_valid/out_stall with out_result, one word per input.
// Stages: input register, then result register.
// Throughput: one word per cycle while out_stall is low. The critical path is one inverse-table
// lookup (constant ROM) feeding one 8x8 carry-less multiply and reduction.
// Stall: the pipeline advances whenever the result register is empty or
// being taken; otherwise both stages hold and in_stall is raised once the
// input stage is full, so no word is lost or repeated.
// Reset (rst_n low, synchronous): both stages empty, out_valid low.
// Payload registers are not reset.
module gf256_arithmetic_unit_top
  import gfau_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [BYTE_W-1:0] in_operand_a,
  input  logic [BYTE_W-1:0] in_operand_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_result
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]   s1_op_r;
  logic [BYTE_W-1:0] s1_a_r;
  logic [BYTE_W-1:0] s1_b_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_result_r, out_result_nxt;

  logic              adv;      // result stage can take a word
  logic              in_take;
  logic [BYTE_W-1:0] mul_y;    // second multiplier operand
  logic [BYTE_W-1:0] prod;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Divide shares the multiplier: a * inv(b); inv(0) = 0 covers zero divisor.
  always_comb begin
    if (s1_op_r == OP_DIV) begin
      mul_y = INV_TBL[s1_b_r];
    end else begin
      mul_y = s1_b_r;
    end
    prod = gf_mul(s1_a_r, mul_y);
  end

  always_comb begin
    case (s1_op_r)
      OP_ADD:  out_result_nxt = s1_a_r ^ s1_b_r;
      OP_SUB:  out_result_nxt = s1_a_r ^ s1_b_r;
      OP_MUL:  out_result_nxt = prod;
      OP_DIV:  out_result_nxt = prod;
      OP_INV:  out_result_nxt = INV_TBL[s1_a_r];
      default: out_result_nxt = '0;
    endcase
  end

  // Input stage fills on a take (even while the result stage holds) and
  // empties when its word moves on without a new one behind it.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_opcode;
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
    if (adv && s1_valid_r) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the GF(2^8) arithmetic unit with a byte scoreboard.
`timescale 1ns / 1ps

import gfau_pkg::*;

typedef struct {
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] want;
} gf_pending_t;

class gf_byte_scoreboard;
  gf_pending_t       pending_bytes[$];
  logic [BYTE_W-1:0] recip_tbl[256];
  int                errors;
  int                checked;
  int                op_count[5];
  int                unused_ops;

  function new();
    errors     = 0;
    checked    = 0;
    unused_ops = 0;
    foreach (op_count[i]) op_count[i] = 0;
    recip_tbl[0] = '0;
    // brute force: y with x*y == 1
    for (int x = 1; x < 256; x++) begin
      for (int y = 1; y < 256; y++) begin
        if (field_times(x[BYTE_W-1:0], y[BYTE_W-1:0]) == 8'h01) begin
          recip_tbl[x] = y[BYTE_W-1:0];
        end
      end
    end
  endfunction

  // carry-less product, reduced by 0x11b as we go
  function logic [BYTE_W-1:0] field_times(logic [BYTE_W-1:0] x, logic [BYTE_W-1:0] y);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] sh;
    acc = '0;
    sh  = x;
    for (int i = 0; i < BYTE_W; i++) begin
      if (y[i]) acc = acc ^ sh;
      sh = sh[BYTE_W-1] ? ({sh[BYTE_W-2:0], 1'b0} ^ GF_REDUCE) : {sh[BYTE_W-2:0], 1'b0};
    end
    return acc;
  endfunction

  function logic [BYTE_W-1:0] field_op_result(logic [OP_W-1:0] op, logic [BYTE_W-1:0] a,
                                              logic [BYTE_W-1:0] b);
    case (op)
      OP_ADD, OP_SUB: return a ^ b;
      OP_MUL:         return field_times(a, b);
      OP_DIV:         return (a == '0 || b == '0) ? '0 : field_times(a, recip_tbl[b]);
      OP_INV:         return recip_tbl[a];
      default:        return '0;
    endcase
  endfunction

  function void note_input(logic [OP_W-1:0] op, logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    gf_pending_t w;
    w.op   = op;
    w.a    = a;
    w.b    = b;
    w.want = field_op_result(op, a, b);
    pending_bytes.push_back(w);
    if (op <= OP_INV) op_count[op]++;
    else unused_ops++;
  endfunction

  function void check_result(logic [BYTE_W-1:0] got);
    gf_pending_t w;
    if (pending_bytes.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: result %02h with no word pending", got);
      return;
    end
    w = pending_bytes.pop_front();
    checked++;
    if (got !== w.want) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: op %0d a %02h b %02h: expected %02h, got %02h",
                 w.op, w.a, w.b, w.want, got);
      end
    end
  endfunction

  function int outstanding();
    return pending_bytes.size();
  endfunction
endclass

module tb;

  localparam logic [OP_W-1:0] OP_LAST = '1;   // top of the reserved opcode range
  localparam int RAND_WORDS = 1300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = OP_ADD;
  logic [BYTE_W-1:0] in_operand_a = '0;
  logic [BYTE_W-1:0] in_operand_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_result;

  // cleared during the quiet stretch: neither side inserts gaps
  bit                gaps_on = 1'b1;

  gf_byte_scoreboard board = new();

  gf256_arithmetic_unit_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  always #10 clk = ~clk;

  // Receiver side: random back-pressure, about 14 percent of the time.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99, 0) < 14);
  end

  // Both handshakes are sampled at the edge itself, so every value read
  // here is the one the block saw when it decided.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_input(in_opcode, in_operand_a, in_operand_b);
      if (out_valid && !out_stall) board.check_result(out_result);
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] a,
                           input logic [BYTE_W-1:0] b);
    while (gaps_on && $urandom_range(99, 0) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Bias toward the interesting bytes: zero, one, all ones.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2:       return 8'h01;
      default: return BYTE_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    logic [OP_W-1:0] legal[5];
    legal = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INV};
    if ($urandom_range(19, 0) < 18) return legal[$urandom_range(4, 0)];
    return OP_W'($urandom_range(OP_LAST, OP_INV + 1));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, each opcode, the zero cases.
    send_word(OP_ADD, 8'h00, 8'h00);
    send_word(OP_ADD, 8'hff, 8'hff);
    send_word(OP_SUB, 8'ha5, 8'h5a);
    send_word(OP_SUB, 8'hff, 8'h00);
    send_word(OP_MUL, 8'h00, 8'h9c);
    send_word(OP_MUL, 8'h9c, 8'h00);
    send_word(OP_MUL, 8'h57, 8'h83);
    send_word(OP_MUL, 8'h80, 8'h02);   // exercises the reduction
    send_word(OP_MUL, 8'hff, 8'hff);
    send_word(OP_DIV, 8'h37, 8'h00);   // zero divisor
    send_word(OP_DIV, 8'h00, 8'h37);   // zero dividend
    send_word(OP_DIV, 8'h00, 8'h00);
    send_word(OP_DIV, 8'hff, 8'hff);
    send_word(OP_DIV, 8'h01, 8'h53);
    send_word(OP_INV, 8'h00, 8'hff);   // inverse of zero
    send_word(OP_INV, 8'h01, 8'h00);
    send_word(OP_INV, 8'h53, 8'h12);
    send_word(OP_INV, 8'hff, 8'hff);
    for (int op = OP_INV + 1; op <= OP_LAST; op++) begin
      send_word(op[OP_W-1:0], 8'hc3, 8'h3c);
    end

    // Random words; a quiet stretch in the middle, one drain pause later.
    for (int n = 0; n < RAND_WORDS; n++) begin
      gaps_on = !(n >= 300 && n < 600);
      if (n == 800) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
      end
      send_word(pick_op(), pick_byte(), pick_byte());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d words: add %0d, sub %0d, mul %0d, div %0d, inv %0d, reserved %0d",
             board.checked, board.op_count[OP_ADD], board.op_count[OP_SUB],
             board.op_count[OP_MUL], board.op_count[OP_DIV], board.op_count[OP_INV],
             board.unused_ops);
    $display("Random gaps and back-pressure on both sides, one gap-free stretch, one drain.");
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors", board.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Timeout with %0d words outstanding", board.outstanding());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
sv/gfau_pkg.sv
sv/gf256_arithmetic_unit_top.sv
sim/tb.sv
